FILE: hdl/cfelw_pkg.sv
// ----------------------------------------------------------------------------
// cfelw_pkg: shared types and constants for the CRC-framed event log writer
// Item layouts, job record, result kinds and the CRC-32C byte table.
// ----------------------------------------------------------------------------
package cfelw_pkg;

  localparam int unsigned MAX_EVENT_BYTES = 4194304;
  localparam int unsigned COUNT_W         = $clog2(MAX_EVENT_BYTES) + 1;
  localparam int unsigned FRAME_HALF      = 16;
  localparam int unsigned FRAME_BYTES     = 2 * FRAME_HALF;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT =
    COUNT_W'(MAX_EVENT_BYTES - FRAME_BYTES);

  localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_CLOSE  = 1'b1;

  localparam logic [3:0] BYTES_NONE    = 4'd0;
  localparam logic [3:0] BYTES_PAYLOAD = 4'd1;
  localparam logic [3:0] BYTES_WORD    = 4'd8;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  data_byte;
    logic [31:0] event_type;
  } in_item_t;

  typedef struct packed {
    logic [63:0] write_offset;
    logic [63:0] write_data;
    logic [3:0]  write_bytes;
    kind_t       kind;
    logic        last;
  } out_item_t;

  typedef struct packed {
    kind_t              jkind;
    logic [63:0]        base;
    logic [63:0]        tail;
    logic [COUNT_W-1:0] plen;
    logic [31:0]        etype;
    logic [31:0]        crc;
    logic [7:0]         dbyte;
  } job_t;

  typedef logic [31:0] crc_tab_t [256];

  function automatic crc_tab_t crc_gen_table();
    crc_tab_t    tab;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      tab[i] = c;
    end
    return tab;
  endfunction

  localparam crc_tab_t CRC_TABLE = crc_gen_table();

endpackage

FILE: hdl/cfelw_front.sv
// ----------------------------------------------------------------------------
// cfelw_front: request intake and classification
// Holds per-event state, folds payload bytes into the CRC and queues jobs.
// ----------------------------------------------------------------------------
module cfelw_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cfelw_pkg::in_item_t in_data,
  input  logic               full,
  output logic               push,
  output cfelw_pkg::job_t    job
);
  import cfelw_pkg::*;

  logic [63:0]        start;
  logic [COUNT_W-1:0] count;
  logic [31:0]        crc;
  logic               ovf;

  logic [63:0]        start_next;
  logic [COUNT_W-1:0] count_next;
  logic [31:0]        crc_next;
  logic               ovf_next;

  logic               accept;
  logic [63:0]        pay_off;

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  assign pay_off  = start + 64'(FRAME_HALF) + 64'(count);

  always_comb begin
    start_next = start;
    count_next = count;
    crc_next   = crc;
    ovf_next   = ovf;
    push       = 1'b0;
    job.jkind  = KIND_PAYLOAD;
    job.base   = pay_off;
    job.tail   = pay_off;
    job.plen   = count;
    job.etype  = in_data.event_type;
    job.crc    = crc ^ CRC_ALL_ONES;
    job.dbyte  = in_data.data_byte;
    if (accept) begin
      if (in_data.action == ACT_APPEND) begin
        if (ovf || count >= COUNT_LIMIT) begin
          // drop byte
          ovf_next = 1'b1;
        end else begin
          push       = 1'b1;
          crc_next   = (crc >> 8) ^ CRC_TABLE[crc[7:0] ^ in_data.data_byte];
          count_next = count + COUNT_W'(1);
        end
      end else begin
        push      = 1'b1;
        job.base  = start;
        job.jkind = ovf ? KIND_REJECT : KIND_FRAME;
        if (!ovf) begin
          start_next = start + 64'(count) + 64'(FRAME_BYTES);
        end
        count_next = '0;
        crc_next   = CRC_ALL_ONES;
        ovf_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= '0;
      count <= '0;
      crc   <= CRC_ALL_ONES;
      ovf   <= 1'b0;
    end else begin
      start <= start_next;
      count <= count_next;
      crc   <= crc_next;
      ovf   <= ovf_next;
    end
  end

endmodule

FILE: hdl/cfelw_queue.sv
// ----------------------------------------------------------------------------
// cfelw_queue: two-entry job queue
// Decouples intake from result generation.
// ----------------------------------------------------------------------------
module cfelw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cfelw_pkg::job_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output cfelw_pkg::job_t head
);
  import cfelw_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full     = (fill == 2'd2);
  assign nonempty = (fill != 2'd0);
  assign head     = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: hdl/cfelw_back.sv
// ----------------------------------------------------------------------------
// cfelw_back: result generation
// Expands queued jobs into addressed writes, one per cycle while the output is
// not stalled, into an output register; holds the sentinel magic register.
// ----------------------------------------------------------------------------
module cfelw_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [63:0]         cfg_data,
  input  logic                nonempty,
  input  cfelw_pkg::job_t     head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output cfelw_pkg::out_item_t out_data
);
  import cfelw_pkg::*;

  localparam logic [1:0] BEAT_HDR0 = 2'd0;
  localparam logic [1:0] BEAT_HDR1 = 2'd1;
  localparam logic [1:0] BEAT_SEN0 = 2'd2;
  localparam logic [1:0] BEAT_SEN1 = 2'd3;

  logic [63:0] magic;
  logic [1:0]  beat;
  logic        advance;
  logic        final_beat;
  out_item_t   res;

  assign cfg_ready = 1'b1;
  assign advance   = nonempty && (!out_valid || out_ready);
  assign pop       = advance && final_beat;

  always_comb begin
    res.kind        = head.jkind;
    res.write_offset = head.base;
    res.write_data  = 64'(head.dbyte);
    res.write_bytes = BYTES_PAYLOAD;
    res.last        = 1'b1;
    final_beat      = 1'b1;
    case (head.jkind)
      KIND_PAYLOAD: begin
      end
      KIND_REJECT: begin
        res.write_data  = '0;
        res.write_bytes = BYTES_NONE;
      end
      KIND_FRAME: begin
        res.write_bytes = BYTES_WORD;
        final_beat      = (beat == BEAT_SEN1);
        res.last        = final_beat;
        case (beat)
          BEAT_HDR0: begin
            res.write_offset = head.base;
            res.write_data   = {head.etype, 32'(head.plen)};
          end
          BEAT_HDR1: begin
            res.write_offset = head.base + 64'd8;
            res.write_data   = {head.crc, 32'd0};
          end
          BEAT_SEN0: begin
            res.write_offset = head.tail;
            res.write_data   = magic;
          end
          default: begin
            res.write_offset = head.tail + 64'd8;
            res.write_data   = head.base;
          end
        endcase
      end
      default: begin
        res.kind        = KIND_REJECT;
        res.write_data  = '0;
        res.write_bytes = BYTES_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic     <= '0;
      beat      <= BEAT_HDR0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        magic <= cfg_data;
      end
      if (advance) begin
        out_valid <= 1'b1;
        beat      <= final_beat ? BEAT_HDR0 : beat + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/crc_framed_event_log_writer.sv
// Each job is registered in the job queue, its result in the output register.
// Throughput: 1 payload byte per cycle unless the queue is full or the output
// stalls; a close makes four word writes, a reject one empty write.
// Intake runs ahead of results through a 2-entry job queue.
// Reset (rst, synchronous): offset and count 0, CRC all ones, magic 0, queue
// empty; no result valid.
// ----------------------------------------------------------------------------
// crc_framed_event_log_writer: top level of the CRC-framed event log writer
// Frames payload bytes into log records with header, CRC-32C and sentinel.
// ----------------------------------------------------------------------------
module crc_framed_event_log_writer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [63:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cfelw_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cfelw_pkg::out_item_t out_data
);
  import cfelw_pkg::*;

  job_t push_job;
  job_t head_job;
  logic push;
  logic full;
  logic pop;
  logic nonempty;

  cfelw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .full     (full),
    .push     (push),
    .job      (push_job)
  );

  cfelw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .head      (head_job)
  );

  cfelw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .nonempty  (nonempty),
    .head      (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/cfelw_checker.sv
// ----------------------------------------------------------------------------
// cfelw_checker: port-level checks for the event log writer
// Watches the result channel for consistent kinds, sizes and handshakes.
// ----------------------------------------------------------------------------
module cfelw_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input cfelw_pkg::out_item_t out_data
);
  import cfelw_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_PAYLOAD |->
      out_data.write_bytes == BYTES_PAYLOAD && out_data.last)
    else $error("payload write malformed");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_REJECT |->
      out_data.write_bytes == BYTES_NONE && out_data.write_data == 64'd0 &&
      out_data.last)
    else $error("reject malformed");

  a_frame_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.kind == KIND_FRAME && !out_data.last |=>
      out_valid && out_data.kind == KIND_FRAME &&
      out_data.write_bytes == BYTES_WORD)
    else $error("frame word sequence broken");

endmodule

bind crc_framed_event_log_writer cfelw_checker u_cfelw_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: bench/tb_crc_framed_event_log_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc_framed_event_log_writer: self-checking bench for the event log framer
// Drives append and close requests through a directed table, then random
// events under several magic settings. Every log write is predicted (offsets,
// CRC-32C, header and sentinel words) and compared field by field against the
// block's output.
// ----------------------------------------------------------------------------
module tb_crc_framed_event_log_writer;
  import cfelw_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct packed {
    in_item_t  item;
    logic      chk;
    out_item_t exp;
  } dir_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  logic        dir_chk   = 1'b0;
  out_item_t   dir_exp   = '0;

  logic [63:0]        magic_q;
  logic [63:0]        start_q;
  logic [COUNT_W-1:0] count_q;
  logic [31:0]        crc_q;
  logic               ovf_q;

  out_item_t   pending_writes [$];
  dir_row_t    dir_tab [$];
  int          err_count   = 0;
  int          idle_cycles = 0;
  int          burst_left  = 0;
  bit          rx_phase    = 1'b0;
  int          rx_left     = 0;

  crc_framed_event_log_writer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] crc32c_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic out_item_t log_write(logic [63:0] off, logic [63:0] data,
                                          logic [3:0] nb, kind_t k, logic lst);
    out_item_t r;
    r.write_offset = off;
    r.write_data   = data;
    r.write_bytes  = nb;
    r.kind         = k;
    r.last         = lst;
    return r;
  endfunction

  function automatic dir_row_t row(logic act, logic [7:0] b, logic [31:0] et,
                                   logic chk, out_item_t exp);
    dir_row_t r;
    r.item.action     = act;
    r.item.data_byte  = b;
    r.item.event_type = et;
    r.chk             = chk;
    r.exp             = exp;
    return r;
  endfunction

  task automatic clear_event();
    count_q = '0;
    crc_q   = CRC_ALL_ONES;
    ovf_q   = 1'b0;
  endtask

  task automatic frame_log_writes(input in_item_t it);
    logic [63:0] tail;
    if (it.action == ACT_APPEND) begin
      if (ovf_q || count_q >= COUNT_LIMIT) begin
        ovf_q = 1'b1;
      end else begin
        pending_writes.push_back(log_write(start_q + 64'(FRAME_HALF) + 64'(count_q),
                                           {56'd0, it.data_byte}, BYTES_PAYLOAD,
                                           KIND_PAYLOAD, 1'b1));
        crc_q   = crc32c_byte(crc_q, it.data_byte);
        count_q = count_q + 1'b1;
      end
    end else if (ovf_q) begin
      pending_writes.push_back(log_write(start_q, '0, BYTES_NONE, KIND_REJECT, 1'b1));
      clear_event();
    end else begin
      tail = start_q + 64'(FRAME_HALF) + 64'(count_q);
      pending_writes.push_back(log_write(start_q, {it.event_type, 32'(count_q)},
                                         BYTES_WORD, KIND_FRAME, 1'b0));
      pending_writes.push_back(log_write(start_q + 64'd8, {crc_q ^ CRC_ALL_ONES, 32'd0},
                                         BYTES_WORD, KIND_FRAME, 1'b0));
      pending_writes.push_back(log_write(tail, magic_q, BYTES_WORD, KIND_FRAME, 1'b0));
      pending_writes.push_back(log_write(tail + 64'd8, start_q, BYTES_WORD,
                                         KIND_FRAME, 1'b1));
      start_q = tail + 64'(FRAME_HALF);
      clear_event();
    end
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch %s: got %h want %h", field, got, want);
    err_count++;
  endtask

  task automatic check_write(input out_item_t got);
    out_item_t want;
    if (pending_writes.size() == 0) begin
      note_mismatch("unexpected request, offset", got.write_offset, '0);
    end else begin
      want = pending_writes.pop_front();
      if (got.write_offset !== want.write_offset)
        note_mismatch("write_offset", got.write_offset, want.write_offset);
      if (got.write_data !== want.write_data)
        note_mismatch("write_data", got.write_data, want.write_data);
      if (got.write_bytes !== want.write_bytes)
        note_mismatch("write_bytes", 64'(got.write_bytes), 64'(want.write_bytes));
      if (got.kind !== want.kind)
        note_mismatch("kind", 64'(got.kind), 64'(want.kind));
      if (got.last !== want.last)
        note_mismatch("last", 64'(got.last), 64'(want.last));
    end
  endtask

  always @(posedge clk) begin
    int slot;
    if (rst) begin
      magic_q     = '0;
      start_q     = '0;
      clear_event();
      idle_cycles = 0;
    end else begin
      if (out_valid && out_ready) check_write(out_data);
      if (in_valid && in_ready) begin
        slot = pending_writes.size();
        frame_log_writes(in_data);
        if (dir_chk && pending_writes.size() > slot) pending_writes[slot] = dir_exp;
      end
      if (cfg_valid && cfg_ready) magic_q = cfg_data;
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_phase = ~rx_phase;
      if (rx_phase)
        rx_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                              : $urandom_range(1, 30);
      else
        rx_left = $urandom_range(1, 8);
    end
    rx_left = rx_left - 1;
    out_ready <= rx_phase;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(negedge clk);
    $display("tb_crc_framed_event_log_writer: errors");
    $finish;
  end

  task automatic send_item(input in_item_t it, input logic chk, input out_item_t exp);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    dir_chk  <= chk;
    dir_exp  <= exp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_random(input logic act);
    in_item_t it;
    it.action     = act;
    it.data_byte  = 8'($urandom);
    it.event_type = $urandom;
    send_item(it, 1'b0, '0);
  endtask

  task automatic write_magic(input logic [63:0] v);
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_events(input int n_items);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(1, 8);
      else if (pick < 88) len = $urandom_range(9, 40);
      else                len = 0;
      for (int j = 0; j < len; j++) send_random(ACT_APPEND);
      send_random(ACT_CLOSE);
      sent += len + 1;
    end
  endtask

  initial begin
    in_item_t it;

    // reset state: start 0, magic 0
    dir_tab.push_back(row(ACT_CLOSE, 8'hFF, 32'hFFFF_FFFF, 1'b1,
      log_write(64'd0, {32'hFFFF_FFFF, 32'd0}, BYTES_WORD, KIND_FRAME, 1'b0)));
    dir_tab.push_back(row(ACT_APPEND, 8'h00, 32'hFFFF_FFFF, 1'b1,
      log_write(64'd48, 64'h00, BYTES_PAYLOAD, KIND_PAYLOAD, 1'b1)));
    dir_tab.push_back(row(ACT_APPEND, 8'hFF, 32'h0000_0000, 1'b1,
      log_write(64'd49, 64'hFF, BYTES_PAYLOAD, KIND_PAYLOAD, 1'b1)));
    dir_tab.push_back(row(ACT_APPEND, 8'h80, 32'h8000_0000, 1'b0, '0));
    dir_tab.push_back(row(ACT_APPEND, 8'h01, 32'h0000_0001, 1'b0, '0));
    dir_tab.push_back(row(ACT_CLOSE, 8'h00, 32'h0000_0000, 1'b1,
      log_write(64'd32, {32'd0, 32'd4}, BYTES_WORD, KIND_FRAME, 1'b0)));
    for (int c = 8'h31; c <= 8'h39; c++)
      dir_tab.push_back(row(ACT_APPEND, 8'(c), 32'h0, 1'b0, '0));
    dir_tab.push_back(row(ACT_CLOSE, 8'h5A, 32'h1234_5678, 1'b1,
      log_write(64'd68, {32'h1234_5678, 32'd9}, BYTES_WORD, KIND_FRAME, 1'b0)));
    dir_tab.push_back(row(ACT_CLOSE, 8'h00, 32'h8000_0000, 1'b0, '0));
    dir_tab.push_back(row(ACT_APPEND, 8'h5A, 32'hA5A5_A5A5, 1'b0, '0));
    dir_tab.push_back(row(ACT_CLOSE, 8'hA5, 32'h0000_0001, 1'b0, '0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].chk, dir_tab[i].exp);

    write_magic(64'hFFFF_FFFF_FFFF_FFFF);
    run_events(130);
    write_magic({$urandom, $urandom});
    run_events(130);
    write_magic(64'h8000_0000_0000_0001);
    run_events(130);

    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("tb_crc_framed_event_log_writer: clean");
    else
      $display("tb_crc_framed_event_log_writer: errors");
    $finish;
  end

endmodule
